// File: design/smac_pkg.sv
`default_nettype none

package smac_pkg;

    // Window lengths and price width
    localparam int SHORT_LEN  = 20;
    localparam int LONG_LEN   = 50;
    localparam int PRICE_BITS = 32;

    // Derived widths
    localparam int CNT_W  = $clog2(LONG_LEN + 1);
    localparam int SDIV_W = $clog2(SHORT_LEN + 1);
    localparam int SSUM_W = PRICE_BITS + SDIV_W;
    localparam int LSUM_W = PRICE_BITS + CNT_W;
    localparam int LHS_W  = SSUM_W + CNT_W;
    localparam int RHS_W  = LSUM_W + SDIV_W;
    localparam int PROD_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // Short-versus-long relation of the averages
    typedef enum logic [1:0] {
        REL_EQUAL = 2'd0,
        REL_BELOW = 2'd1,
        REL_ABOVE = 2'd2
    } rel_t;

    // Item leaving the delay line stage, with its updated sample count
    typedef struct packed {
        logic                  valid;
        logic [PRICE_BITS-1:0] price;
        logic [CNT_W-1:0]      cnt;
    } stage_t;

endpackage

`default_nettype wire

// File: design/smac_if.sv
`default_nettype none

// Price samples into the detector
interface smac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

// Crossover results out of the detector
interface smac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] signal_price;
    logic        is_sell;

    modport source (output valid, output signal_price, output is_sell, input ready);
    modport sink   (input valid, input signal_price, input is_sell, output ready);
endinterface

`default_nettype wire

// File: design/sma_crossover_detector_top.sv
// Channel    | Dir | Payload                   | Transaction
// -----------+-----+---------------------------+---------------------------
// samples    | in  | price[31:0]               | valid && ready
// crossings  | out | signal_price[31:0], is_sell | valid && ready
//
// One sample per cycle while the output does not stall; a result passes through
// the sums and count registers, the cross multiply registers and a compare into
// the output register.
// rst_n clears counts, sums, relation (equal) and all valid flags at once.
// A stalled output holds the whole pipeline; samples keep flowing while the
// output register is empty or being drained in the same cycle.
`default_nettype none

module sma_crossover_detector_top
    import smac_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    smac_in_if.sink    samples,
    smac_out_if.source crossings
);

    logic                  advance;
    logic                  accept;
    logic [PRICE_BITS-1:0] price;
    logic [PRICE_BITS-1:0] tap [LONG_LEN];

    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic [SSUM_W-1:0] short_sum_reg, short_sum_next;
    logic [LSUM_W-1:0] long_sum_reg,  long_sum_next;
    stage_t            s1_reg,        s1_next;

    assign samples.ready = advance;
    assign accept        = samples.valid && advance;
    assign price         = PRICE_BITS'(samples.price);

    // delay line: cell 0 holds the newest price
    for (genvar i = 0; i < LONG_LEN; i++)
    begin : g_line
        if (i == 0)
        begin : g_head
            smac_cell u_cell (
                .clk   (clk),
                .shift (accept),
                .d     (price),
                .q     (tap[i])
            );
        end
        else
        begin : g_body
            smac_cell u_cell (
                .clk   (clk),
                .shift (accept),
                .d     (tap[i-1]),
                .q     (tap[i])
            );
        end
    end

    // running sums and saturating count
    always_comb
    begin
        cnt_next       = cnt_reg;
        short_sum_next = short_sum_reg;
        long_sum_next  = long_sum_reg;
        s1_next        = s1_reg;
        if (advance)
            s1_next.valid = 1'b0;
        if (accept)
        begin
            if (cnt_reg >= CNT_W'(SHORT_LEN))
                short_sum_next = short_sum_reg + SSUM_W'(price)
                                 - SSUM_W'(tap[SHORT_LEN-1]);
            else
                short_sum_next = short_sum_reg + SSUM_W'(price);

            if (cnt_reg >= CNT_W'(LONG_LEN))
                long_sum_next = long_sum_reg + LSUM_W'(price)
                                - LSUM_W'(tap[LONG_LEN-1]);
            else
                long_sum_next = long_sum_reg + LSUM_W'(price);

            if (cnt_reg < CNT_W'(LONG_LEN))
                cnt_next = cnt_reg + CNT_W'(1);

            s1_next.valid = 1'b1;
            s1_next.price = price;
            s1_next.cnt   = cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            s1_reg        <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
            s1_reg        <= s1_next;
        end
    end

    // cross multiply, compare and output
    smac_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1_reg),
        .short_sum (short_sum_reg),
        .long_sum  (long_sum_reg),
        .advance   (advance),
        .crossings (crossings)
    );

endmodule

`default_nettype wire

// File: design/smac_cell.sv
`default_nettype none

// One element of the price delay line
module smac_cell
    import smac_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  shift,
    input  wire logic [PRICE_BITS-1:0] d,
    output logic      [PRICE_BITS-1:0] q
);

    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] price_next;

    // take the neighbor's price on every transaction
    always_comb
    begin
        price_next = shift ? d : price_reg;
    end

    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
    end

    assign q = price_reg;

endmodule

`default_nettype wire

// File: design/smac_eval.sv
`default_nettype none

// Cross-multiply stage, compare stage and output register
module smac_eval
    import smac_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stage_t            s1,
    input  wire logic [SSUM_W-1:0] short_sum,
    input  wire logic [LSUM_W-1:0] long_sum,
    output logic                   advance,
    smac_out_if.source             crossings
);

    logic                  s2_valid_reg,  s2_valid_next;
    logic                  s2_full_reg,   s2_full_next;
    logic [PRICE_BITS-1:0] s2_price_reg,  s2_price_next;
    logic [PROD_W-1:0]     lhs_reg,       lhs_next;
    logic [PROD_W-1:0]     rhs_reg,       rhs_next;
    rel_t                  prior_reg,     prior_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_price_reg, out_price_next;
    logic                  out_sell_reg,  out_sell_next;

    logic [SDIV_W-1:0] sdiv;
    rel_t              rel;
    logic              buy;
    logic              sell;

    // pipeline moves whenever the output register is free or being drained
    assign advance = !out_valid_reg || crossings.ready;

    // divisors: count capped at each window
    always_comb
    begin
        if (s1.cnt < CNT_W'(SHORT_LEN))
            sdiv = SDIV_W'(s1.cnt);
        else
            sdiv = SDIV_W'(SHORT_LEN);
    end

    // stage 2: cross products
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_full_next  = s2_full_reg;
        s2_price_next = s2_price_reg;
        lhs_next      = lhs_reg;
        rhs_next      = rhs_reg;
        if (advance)
        begin
            s2_valid_next = s1.valid;
            s2_full_next  = (s1.cnt == CNT_W'(LONG_LEN));
            s2_price_next = s1.price;
            lhs_next      = PROD_W'(short_sum) * PROD_W'(s1.cnt);
            rhs_next      = PROD_W'(long_sum) * PROD_W'(sdiv);
        end
    end

    // stage 3: relation and crossover decision
    always_comb
    begin
        if (lhs_reg < rhs_reg)
            rel = REL_BELOW;
        else if (lhs_reg > rhs_reg)
            rel = REL_ABOVE;
        else
            rel = REL_EQUAL;
        buy  = s2_full_reg && (prior_reg == REL_BELOW) && (rel != REL_BELOW);
        sell = s2_full_reg && (prior_reg == REL_ABOVE) && (rel != REL_ABOVE);
    end

    always_comb
    begin
        prior_next     = prior_reg;
        out_valid_next = out_valid_reg;
        out_price_next = out_price_reg;
        out_sell_next  = out_sell_reg;
        if (advance)
        begin
            out_valid_next = s2_valid_reg && (buy || sell);
            out_price_next = 32'(s2_price_reg);
            out_sell_next  = sell;
            if (s2_valid_reg)
                prior_next = rel;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            prior_reg     <= REL_EQUAL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            prior_reg     <= prior_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s2_full_reg   <= s2_full_next;
        s2_price_reg  <= s2_price_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        out_price_reg <= out_price_next;
        out_sell_reg  <= out_sell_next;
    end

    assign crossings.valid        = out_valid_reg;
    assign crossings.signal_price = out_price_reg;
    assign crossings.is_sell      = out_sell_reg;

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb
    import smac_pkg::*;
();

    localparam int    LONG_HOLD     = 200;
    localparam int    DRAIN_CYCLES  = 12;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam longint PRICE_MAX    = 64'h0000_0000_FFFF_FFFF;

    // Kinds of price segments in the random stream
    typedef enum int {
        SEG_WAVE,
        SEG_TREND,
        SEG_FLAT,
        SEG_NOISE,
        SEG_EXTREME
    } seg_kind_t;

    // One expected crossover
    typedef struct {
        logic [31:0] price;
        logic        sell;
    } crossing_t;

    logic clk;
    logic rst_n;

    smac_in_if  samples();
    smac_out_if crossings();

    sma_crossover_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .crossings (crossings)
    );

    // Predictor state: delay line, window sums, count and last relation
    logic [PRICE_BITS-1:0] hist [LONG_LEN];
    int                    wr_idx;
    logic [SSUM_W-1:0]     short_acc;
    logic [LSUM_W-1:0]     long_acc;
    int                    seen_cnt;
    rel_t                  last_rel;

    crossing_t crossing_q[$];

    int  errors;
    int  items_sent;
    int  results_seen;
    int  buys_seen;
    int  sells_seen;
    int  cycle_cnt;
    bit  tx_idle;
    bit  rx_idle;
    bit  long_hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d crossings pending",
                     $time, cycle_cnt, crossing_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Advance the predictor by one sample; queue a crossover if one fires
    task automatic track_sample(input logic [31:0] raw);
        logic [PRICE_BITS-1:0] p;
        int                    drop_idx;
        logic [SDIV_W-1:0]     sdiv;
        logic [CNT_W-1:0]      ldiv;
        logic [PROD_W-1:0]     lhs;
        logic [PROD_W-1:0]     rhs;
        rel_t                  rel;
        rel_t                  was;
        crossing_t             c;
        p = raw[PRICE_BITS-1:0];
        // short window drops the sample SHORT_LEN back
        if (seen_cnt >= SHORT_LEN)
        begin
            drop_idx  = (wr_idx + LONG_LEN - (SHORT_LEN % LONG_LEN)) % LONG_LEN;
            short_acc = short_acc + p - hist[drop_idx];
        end
        else
            short_acc = short_acc + p;
        // long window drops the oldest sample once full
        if (seen_cnt >= LONG_LEN)
            long_acc = long_acc + p - hist[wr_idx];
        else
            long_acc = long_acc + p;
        hist[wr_idx] = p;
        wr_idx = (wr_idx + 1) % LONG_LEN;
        if (seen_cnt < LONG_LEN)
            seen_cnt++;
        // exact compare of averages by cross multiplication
        sdiv = (seen_cnt < SHORT_LEN) ? SDIV_W'(seen_cnt) : SDIV_W'(SHORT_LEN);
        ldiv = (seen_cnt < LONG_LEN) ? CNT_W'(seen_cnt) : CNT_W'(LONG_LEN);
        lhs  = short_acc * ldiv;
        rhs  = long_acc * sdiv;
        if (lhs < rhs)
            rel = REL_BELOW;
        else if (lhs > rhs)
            rel = REL_ABOVE;
        else
            rel = REL_EQUAL;
        was      = last_rel;
        last_rel = rel;
        if (seen_cnt >= LONG_LEN)
        begin
            c.price = 32'(p);
            if (was == REL_BELOW && rel != REL_BELOW)
            begin
                c.sell = 1'b0;
                crossing_q = {crossing_q, c};
            end
            else if (was == REL_ABOVE && rel != REL_ABOVE)
            begin
                c.sell = 1'b1;
                crossing_q = {crossing_q, c};
            end
        end
    endtask

    // Offer one price; returns after the edge that takes it
    task automatic send_price(input logic [31:0] p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            samples.valid = 1'b0;
        end
        @(negedge clk);
        samples.valid = 1'b1;
        samples.price = p;
        forever
        begin
            @(posedge clk);
            if (samples.ready)
                break;
        end
        items_sent++;
        track_sample(p);
    endtask

    // Stop offering and let every pending crossover come out
    task automatic wait_for_drain();
        @(negedge clk);
        samples.valid = 1'b0;
        while (crossing_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [31:0] clamp_price(input longint v);
        if (v < 0)
            return 32'd0;
        if (v > PRICE_MAX)
            return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // Triangle wave around a random level: crosses regularly
    task automatic send_wave(input int len, input int max_period);
        longint base;
        longint amp;
        int     period;
        int     ph;
        int     tri_pos;
        longint v;
        base   = longint'($urandom);
        period = $urandom_range(8, max_period);
        case ($urandom_range(0, 2))
            0: amp = longint'($urandom_range(1, 1000));
            1: amp = longint'($urandom_range(1000, 1 << 20));
            default: amp = longint'($urandom_range(1 << 20, 32'h7FFF_FFFF));
        endcase
        for (int i = 0; i < len; i++)
        begin
            ph      = i % period;
            tri_pos = (ph < period / 2) ? ph : period - ph;
            v = base - amp / 2 + (longint'(tri_pos) * 2 * amp) / period
                + longint'($urandom_range(0, 3));
            send_price(clamp_price(v));
        end
    endtask

    // Drifting random walk
    task automatic send_trend(input int len);
        longint lvl;
        longint drift;
        lvl   = longint'($urandom);
        drift = longint'($urandom_range(0, 1 << 16));
        if ($urandom_range(0, 1))
            drift = -drift;
        for (int i = 0; i < len; i++)
        begin
            lvl = lvl + drift + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            if (lvl < 0)
                lvl = 0;
            if (lvl > PRICE_MAX)
                lvl = PRICE_MAX;
            send_price(lvl[31:0]);
        end
    endtask

    // One random segment of the stream
    task automatic send_segment();
        int          pick;
        seg_kind_t   kind;
        logic [31:0] level;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            kind = SEG_WAVE;
        else if (pick < 12)
            kind = SEG_TREND;
        else if (pick < 14)
            kind = SEG_FLAT;
        else if (pick < 17)
            kind = SEG_NOISE;
        else
            kind = SEG_EXTREME;
        case (kind)
            SEG_WAVE:
                send_wave($urandom_range(30, 120), 120);
            SEG_TREND:
                send_trend($urandom_range(20, 80));
            SEG_FLAT:
            begin
                // long enough for both averages to meet exactly
                case ($urandom_range(0, 3))
                    0: level = 32'd0;
                    1: level = 32'hFFFF_FFFF;
                    default: level = $urandom;
                endcase
                repeat ($urandom_range(50, 60))
                    send_price(level);
            end
            SEG_NOISE:
                repeat ($urandom_range(5, 25))
                    send_price($urandom);
            default:
                repeat ($urandom_range(5, 20))
                begin
                    case ($urandom_range(0, 3))
                        0: send_price(32'd0);
                        1: send_price(32'hFFFF_FFFF);
                        2: send_price(32'hFFFF_FFFF - $urandom_range(0, 15));
                        default: send_price($urandom_range(0, 15));
                    endcase
                end
        endcase
    endtask

    // Receiver: random stall per result, or one long hold on request
    initial
    begin : result_receiver
        int wait_cycles;
        crossings.ready = 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                wait_cycles   = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
                wait_cycles = rx_idle ? $urandom_range(0, 6) : 0;
            repeat (wait_cycles)
            begin
                @(negedge clk);
                crossings.ready = 1'b0;
            end
            @(negedge clk);
            crossings.ready = 1'b1;
            forever
            begin
                @(posedge clk);
                if (crossings.valid || long_hold_req)
                    break;
            end
        end
    end

    // Compare each crossover with the oldest prediction
    always @(posedge clk)
    begin : crossing_checker
        crossing_t want;
        if (rst_n && crossings.valid && crossings.ready)
        begin
            results_seen++;
            if (crossing_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected crossover price=%h is_sell=%b",
                         $time, crossings.signal_price, crossings.is_sell);
            end
            else
            begin
                want = crossing_q[0];
                crossing_q.delete(0);
                if (want.sell)
                    sells_seen++;
                else
                    buys_seen++;
                if (crossings.signal_price !== want.price)
                begin
                    errors++;
                    $display("%0t: signal_price expected %h actual %h",
                             $time, want.price, crossings.signal_price);
                end
                if (crossings.is_sell !== want.sell)
                begin
                    errors++;
                    $display("%0t: is_sell expected %b actual %b",
                             $time, want.sell, crossings.is_sell);
                end
            end
        end
    end

    // Extremes and bit patterns while the windows warm up
    task automatic test_extremes();
        send_price(32'd0);
        send_price(32'hFFFF_FFFF);
        send_price(32'd0);
        send_price(32'hFFFF_FFFF);
        send_price(32'd1);
        send_price(32'hFFFF_FFFE);
        send_price(32'h8000_0000);
        send_price(32'h7FFF_FFFF);
        send_price(32'h5555_5555);
        send_price(32'hAAAA_AAAA);
        repeat (5)
            send_price(32'hFFFF_FFFF);
        repeat (5)
            send_price(32'd0);
    endtask

    // Random segments with both sides idling
    task automatic test_random_stream(input int n);
        int start;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        start   = items_sent;
        while (items_sent - start < n)
            send_segment();
    endtask

    // Back-to-back on both sides
    task automatic test_full_rate(input int n);
        int start;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        start   = items_sent;
        while (items_sent - start < n)
            send_segment();
    endtask

    // Receiver holds off while samples keep coming: pipeline fills and stalls
    task automatic test_output_backpressure();
        tx_idle       = 1'b0;
        rx_idle       = 1'b1;
        long_hold_req = 1'b1;
        send_wave(120, 24);
    endtask

    // Sender pauses until every crossover is out, then resumes
    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_wave(40, 30);
        wait_for_drain();
        send_wave(40, 30);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        samples.valid = 1'b0;
        samples.price = 32'd0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        long_hold_req = 1'b0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        buys_seen     = 0;
        sells_seen    = 0;
        cycle_cnt     = 0;
        for (int i = 0; i < LONG_LEN; i++)
            hist[i] = '0;
        wr_idx    = 0;
        short_acc = '0;
        long_acc  = '0;
        seen_cnt  = 0;
        last_rel  = REL_EQUAL;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_random_stream(400);
        test_full_rate(150);
        test_output_backpressure();
        test_drain_pause();
        test_random_stream(400);

        wait_for_drain();
        if (crossing_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d crossovers never arrived", $time, crossing_q.size());
        end
        $display("Sent %0d samples; checked %0d crossovers (%0d buy, %0d sell)",
                 items_sent, results_seen, buys_seen, sells_seen);
        $display("Covered warm-up, extremes, flat runs, waves, noise and output stalls");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sma_crossover_detector_top.f
design/smac_pkg.sv
design/smac_if.sv
design/smac_cell.sv
design/smac_eval.sv
design/sma_crossover_detector_top.sv
bench/tb.sv
